@@ src/slbu_pkg.sv @@
// ----------------------------------------------------------------------------
// slbu_pkg
// Shared types, constants and the control program of the shift light bar
// updater.
// ----------------------------------------------------------------------------
package slbu_pkg;

    // Field widths.
    localparam int SPEED_W   = 16;
    localparam int INDEX_W   = 4;
    localparam int CODE_W    = 3;
    localparam int M_TDATA_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Number of LEDs on the bar.
    localparam int LED_COUNT_DEF = 15;

    // Last LED of the green and yellow zones.
    localparam int GREEN_LAST  = 4;
    localparam int YELLOW_LAST = 10;

    // Colour codes.
    localparam logic [CODE_W-1:0] COL_BACKGROUND = 3'd0;
    localparam logic [CODE_W-1:0] COL_GREEN      = 3'd1;
    localparam logic [CODE_W-1:0] COL_YELLOW     = 3'd2;
    localparam logic [CODE_W-1:0] COL_RED        = 3'd3;
    localparam logic [CODE_W-1:0] COL_BLUE       = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_SPAN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_PALETTE = 2'd2;

    // Configuration reset values.
    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 16'd8000;
    localparam logic [SPEED_W-1:0] RAMP_SPAN_RST   = 16'd1200;

    // Micro-operations carried out by the datapath.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_PREP,
        OP_LOAD,
        OP_DIV,
        OP_PLAN,
        OP_EMIT
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_NOT_RAMP,
        JC_DIV_BUSY,
        JC_UNCHANGED,
        JC_EMIT_WAIT
    } cond_t;

    localparam int PC_W = 3;

    // Program step addresses.
    localparam logic [PC_W-1:0] PC_ACCEPT = 3'd0;
    localparam logic [PC_W-1:0] PC_PREP   = 3'd1;
    localparam logic [PC_W-1:0] PC_LOAD   = 3'd2;
    localparam logic [PC_W-1:0] PC_DIV    = 3'd3;
    localparam logic [PC_W-1:0] PC_PLAN   = 3'd4;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd5;
    localparam logic [PC_W-1:0] PC_DONE   = 3'd6;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_word_t;

    // Datapath flags tested by the jump conditions.
    typedef struct packed {
        logic no_input;
        logic not_ramp;
        logic div_busy;
        logic unchanged;
        logic emit_wait;
    } status_t;

    // The control program: one control word per step.
    function automatic ctrl_word_t program_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            PC_ACCEPT: w = '{op: OP_ACCEPT, cond: JC_NO_INPUT,  target: PC_ACCEPT};
            PC_PREP:   w = '{op: OP_PREP,   cond: JC_NOT_RAMP,  target: PC_PLAN};
            PC_LOAD:   w = '{op: OP_LOAD,   cond: JC_NEVER,     target: PC_ACCEPT};
            PC_DIV:    w = '{op: OP_DIV,    cond: JC_DIV_BUSY,  target: PC_DIV};
            PC_PLAN:   w = '{op: OP_PLAN,   cond: JC_UNCHANGED, target: PC_ACCEPT};
            PC_EMIT:   w = '{op: OP_EMIT,   cond: JC_EMIT_WAIT, target: PC_EMIT};
            PC_DONE:   w = '{op: OP_NOP,    cond: JC_ALWAYS,    target: PC_ACCEPT};
            default:   w = '{op: OP_NOP,    cond: JC_ALWAYS,    target: PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

@@ src/slbu_seq.sv @@
// ----------------------------------------------------------------------------
// slbu_seq
// Step counter and control store; picks the next step from the jump
// condition of the current control word.
// ----------------------------------------------------------------------------
module slbu_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  slbu_pkg::status_t     status,
    output slbu_pkg::ctrl_word_t  ctrl
);

    logic [slbu_pkg::PC_W-1:0] pc_reg;
    logic [slbu_pkg::PC_W-1:0] pc_next;
    logic                      take_jump;

    assign ctrl = slbu_pkg::program_rom(pc_reg);

    always_comb begin
        case (ctrl.cond)
            slbu_pkg::JC_NEVER:     take_jump = 1'b0;
            slbu_pkg::JC_ALWAYS:    take_jump = 1'b1;
            slbu_pkg::JC_NO_INPUT:  take_jump = status.no_input;
            slbu_pkg::JC_NOT_RAMP:  take_jump = status.not_ramp;
            slbu_pkg::JC_DIV_BUSY:  take_jump = status.div_busy;
            slbu_pkg::JC_UNCHANGED: take_jump = status.unchanged;
            slbu_pkg::JC_EMIT_WAIT: take_jump = status.emit_wait;
            default:                take_jump = 1'b1;
        endcase
        pc_next = take_jump ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= slbu_pkg::PC_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ src/slbu_datapath.sv @@
// ----------------------------------------------------------------------------
// slbu_datapath
// Ramp arithmetic, shift-subtract divider, repaint planning, bar state and
// the output register, all driven by the control word.
// ----------------------------------------------------------------------------
module slbu_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  slbu_pkg::ctrl_word_t                ctrl,
    output slbu_pkg::status_t                   status,
    input  logic                                s_tvalid,
    input  logic [slbu_pkg::SPEED_W-1:0]        s_speed,
    input  logic [slbu_pkg::SPEED_W-1:0]        speed_limit,
    input  logic [slbu_pkg::SPEED_W-1:0]        ramp_span,
    input  logic                                dark_palette,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [slbu_pkg::INDEX_W-1:0]        m_led_index,
    output logic [slbu_pkg::CODE_W-1:0]         m_color_code,
    output logic                                m_palette_dark,
    output logic                                m_last_of_run
);

    localparam int LED_COUNT = slbu_pkg::LED_COUNT_DEF;
    localparam int CW = $clog2(LED_COUNT + 1);    // lit count width
    localparam int RW = slbu_pkg::SPEED_W + CW;   // divider width
    localparam int BW = $clog2(CW);               // quotient bit counter
    localparam logic [CW-1:0] FULL = CW'(LED_COUNT);

    // Item registers.
    logic [slbu_pkg::SPEED_W-1:0] speed_reg;
    logic [slbu_pkg::SPEED_W-1:0] diff_reg;
    logic [slbu_pkg::SPEED_W-1:0] range_reg;
    logic                         over_reg;
    logic [CW-1:0]                lit_reg;
    logic [RW-1:0]                rem_reg;
    logic [RW-1:0]                den_reg;
    logic [CW-1:0]                quot_reg;
    logic [BW-1:0]                bit_cnt_reg;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                end_reg;

    // Bar state.
    logic [CW-1:0]                prev_lit_reg;
    logic                         painted_reg;
    logic                         prev_pal_reg;
    logic                         prev_over_reg;

    // Output register.
    logic                         m_tvalid_reg;
    logic [slbu_pkg::INDEX_W-1:0] m_led_index_reg;
    logic [slbu_pkg::CODE_W-1:0]  m_color_code_reg;
    logic                         m_palette_dark_reg;
    logic                         m_last_reg;

    logic [slbu_pkg::SPEED_W-1:0] start_c;
    logic [slbu_pkg::SPEED_W-1:0] range_c;
    logic                         over_c;
    logic                         rem_ge;
    logic [CW-1:0]                quot_next;
    logic                         full_c;
    logic                         grow_c;
    logic                         out_free;
    logic                         last_c;
    logic                         emit_fire;
    logic [slbu_pkg::CODE_W-1:0]  code_c;

    function automatic logic [slbu_pkg::CODE_W-1:0] lit_code(
        input logic [CW-1:0] idx,
        input logic          over
    );
        logic [7:0] idx_w;
        idx_w = 8'(idx);
        if (over)
            return slbu_pkg::COL_BLUE;
        else if (idx_w <= 8'(slbu_pkg::GREEN_LAST))
            return slbu_pkg::COL_GREEN;
        else if (idx_w <= 8'(slbu_pkg::YELLOW_LAST))
            return slbu_pkg::COL_YELLOW;
        else
            return slbu_pkg::COL_RED;
    endfunction

    always_comb begin
        start_c   = (speed_limit > ramp_span) ? speed_limit - ramp_span : '0;
        range_c   = (speed_limit > ramp_span) ? ramp_span : speed_limit;
        over_c    = speed_reg >= speed_limit;
        rem_ge    = rem_reg >= den_reg;
        quot_next = {quot_reg[CW-2:0], rem_ge};
        full_c    = !painted_reg || (dark_palette != prev_pal_reg)
                    || (over_reg != prev_over_reg);
        grow_c    = lit_reg > prev_lit_reg;
        out_free  = !m_tvalid_reg || m_tready;
        last_c    = ((CW+1)'(idx_reg) + 1'b1) == (CW+1)'(end_reg);
        emit_fire = (ctrl.op == slbu_pkg::OP_EMIT) && out_free;
        code_c    = (idx_reg < lit_reg) ? lit_code(idx_reg, over_reg)
                                        : slbu_pkg::COL_BACKGROUND;

        status.no_input  = !s_tvalid;
        status.not_ramp  = over_c || !(speed_reg > start_c);
        status.div_busy  = bit_cnt_reg != '0;
        status.unchanged = !full_c && (lit_reg == prev_lit_reg);
        status.emit_wait = !(out_free && last_c);
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_lit_reg  <= '0;
            painted_reg   <= 1'b0;
            prev_pal_reg  <= 1'b0;
            prev_over_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (ctrl.op == slbu_pkg::OP_PLAN && !status.unchanged) begin
                prev_lit_reg  <= lit_reg;
                painted_reg   <= 1'b1;
                prev_pal_reg  <= dark_palette;
                prev_over_reg <= over_reg;
            end
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            slbu_pkg::OP_ACCEPT: begin
                if (s_tvalid) begin
                    speed_reg <= s_speed;
                end
            end
            slbu_pkg::OP_PREP: begin
                over_reg  <= over_c;
                diff_reg  <= speed_reg - start_c;
                range_reg <= range_c;
                lit_reg   <= over_c ? FULL : '0;
            end
            slbu_pkg::OP_LOAD: begin
                rem_reg     <= RW'(diff_reg) * RW'(LED_COUNT);
                den_reg     <= RW'(range_reg) << (CW - 1);
                quot_reg    <= '0;
                bit_cnt_reg <= BW'(CW - 1);
            end
            slbu_pkg::OP_DIV: begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - den_reg;
                end
                den_reg     <= den_reg >> 1;
                quot_reg    <= quot_next;
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    lit_reg <= (quot_next > FULL) ? FULL : quot_next;
                end
            end
            slbu_pkg::OP_PLAN: begin
                if (full_c) begin
                    idx_reg <= '0;
                    end_reg <= FULL;
                end else if (grow_c) begin
                    idx_reg <= prev_lit_reg;
                    end_reg <= lit_reg;
                end else begin
                    idx_reg <= lit_reg;
                    end_reg <= prev_lit_reg;
                end
            end
            slbu_pkg::OP_EMIT: begin
                if (out_free) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (emit_fire) begin
            m_led_index_reg    <= slbu_pkg::INDEX_W'(idx_reg);
            m_color_code_reg   <= code_c;
            m_palette_dark_reg <= dark_palette;
            m_last_reg         <= last_c;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_led_index    = m_led_index_reg;
    assign m_color_code   = m_color_code_reg;
    assign m_palette_dark = m_palette_dark_reg;
    assign m_last_of_run  = m_last_reg;

endmodule

@@ src/shift_light_bar_updater_core.sv @@
// ----------------------------------------------------------------------------
// shift_light_bar_updater_core
// Turns engine speed samples into repaint transfers for a shift light bar.
// ----------------------------------------------------------------------------
// Usage. Each transfer on the s_ channel carries one engine speed sample in
// s_tdata. The block works out how many LEDs of the bar are lit and sends one
// transfer on the m_ channel for every LED whose colour has to change; m_tlast
// marks the final repaint caused by a sample. A sample that changes nothing
// gives no transfer at all. The first sample after reset, and any sample
// where the palette or the over-limit state differs from the last repaint,
// redraws the whole bar.
// Timing. A sample is taken only while the sequencer sits on its input step.
// A sample inside the ramp goes through the one-bit-a-cycle divider, whose
// quotient is CW bits wide, CW being the lit count width (4 bits for 15 LEDs);
// a sample outside the ramp skips the divider. After the division, the plan
// step and then the emit step hand the first repaint to the output register.
// Stalls. A result waits in the output register while m_tready is low, and
// the sequencer holds on its emit step until it can hand over the next one.
// Reset. aresetn is synchronous and active low; it restores the register
// defaults (limit 8000, span 1200, light palette) and forces a full redraw.
// The cfg_ channel is always ready; write it only while no sample is in work.
// ----------------------------------------------------------------------------
module shift_light_bar_updater_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Speed samples.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [slbu_pkg::SPEED_W-1:0]        s_tdata,   // [15:0] engine_speed
    // Repaint commands.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [slbu_pkg::M_TDATA_W-1:0]      m_tdata,   // [3:0] led_index,
                                                           // [6:4] color_code,
                                                           // [7] palette_dark
    output logic                                m_tlast,   // last_of_run
    // Register writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slbu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slbu_pkg::CFG_DAT_W-1:0]      cfg_data
);

    logic [slbu_pkg::SPEED_W-1:0] speed_limit_reg;
    logic [slbu_pkg::SPEED_W-1:0] ramp_span_reg;
    logic                         dark_palette_reg;

    slbu_pkg::ctrl_word_t         ctrl;
    slbu_pkg::status_t            status;

    logic [slbu_pkg::INDEX_W-1:0] led_index;
    logic [slbu_pkg::CODE_W-1:0]  color_code;
    logic                         palette_dark;

    // Configuration registers; the port never stalls. Writes to an index
    // beyond the register list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg  <= slbu_pkg::SPEED_LIMIT_RST;
            ramp_span_reg    <= slbu_pkg::RAMP_SPAN_RST;
            dark_palette_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                slbu_pkg::CFG_SPEED_LIMIT:  speed_limit_reg  <= cfg_data;
                slbu_pkg::CFG_RAMP_SPAN:    ramp_span_reg    <= cfg_data;
                slbu_pkg::CFG_DARK_PALETTE: dark_palette_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The input is open only on the accept step of the program.
    assign s_tready = (ctrl.op == slbu_pkg::OP_ACCEPT);

    slbu_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    slbu_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .status         (status),
        .s_tvalid       (s_tvalid),
        .s_speed        (s_tdata),
        .speed_limit    (speed_limit_reg),
        .ramp_span      (ramp_span_reg),
        .dark_palette   (dark_palette_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_led_index    (led_index),
        .m_color_code   (color_code),
        .m_palette_dark (palette_dark),
        .m_last_of_run  (m_tlast)
    );

    assign m_tdata = {palette_dark, color_code, led_index};

endmodule

@@ tb/sv/tb_shift_light_bar_updater_core.sv @@
// ----------------------------------------------------------------------------
// tb_shift_light_bar_updater_core
// Self-checking testbench for the shift light bar updater core.
// ----------------------------------------------------------------------------
// A short table of directed samples and register writes is walked first.
// Random phases follow, each with fresh register settings and samples that
// mostly sweep the ramp. A behavioural model of the bar predicts every repaint
// transfer, and a monitor checks each transfer on the m_ channel against the
// oldest prediction. The sender works in bursts and the receiver stalls to a
// pattern of its own. A watchdog ends the run if transfers stop.
// ----------------------------------------------------------------------------
module tb_shift_light_bar_updater_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BAR_LEDS     = slbu_pkg::LED_COUNT_DEF;
    localparam int SETTLE_CYC   = 30;    // covers a sample that repaints nothing
    localparam int DRAIN_CYC    = 40;
    localparam int WATCHDOG_CYC = 5000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 18;

    // Kinds of row in the directed table.
    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // One row of the directed table. For a sample row with known_level set,
    // the lit count and the over-limit flag are typed in directly rather than
    // worked out by the bar model.
    typedef struct {
        row_kind_t                          kind;
        logic [slbu_pkg::CFG_IDX_W-1:0]     reg_idx;
        logic [slbu_pkg::CFG_DAT_W-1:0]     value;
        bit                                 known_level;
        int                                 lit;
        bit                                 over;
    } stim_row_t;

    typedef struct {
        int unsigned lit;
        bit          over;
    } bar_level_t;

    typedef struct packed {
        logic [slbu_pkg::INDEX_W-1:0] led;
        logic [slbu_pkg::CODE_W-1:0]  colour;
        logic                         dark;
        logic                         last;
    } repaint_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals of the block.
    // ------------------------------------------------------------------------
    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [slbu_pkg::SPEED_W-1:0]       s_tdata   = '0;   // [15:0] engine_speed
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [slbu_pkg::M_TDATA_W-1:0]     m_tdata;          // [3:0] led_index,
                                                          // [6:4] color_code,
                                                          // [7] palette_dark
    logic                               m_tlast;          // last_of_run
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [slbu_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [slbu_pkg::CFG_DAT_W-1:0]     cfg_data  = '0;

    shift_light_bar_updater_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bar model: its own copy of the registers and of the painted state.
    // ------------------------------------------------------------------------
    int unsigned    reg_limit = 32'(slbu_pkg::SPEED_LIMIT_RST);
    int unsigned    reg_span  = 32'(slbu_pkg::RAMP_SPAN_RST);
    logic           reg_dark  = 1'b0;

    int unsigned    shown_lit   = 0;
    bit             shown_once  = 1'b0;
    logic           shown_dark  = 1'b0;
    bit             shown_over  = 1'b0;

    // Repaints still to arrive on the m_ channel, oldest first.
    repaint_t       repaint_q[$];

    int             fail_count  = 0;
    int             idle_cycles = 0;
    int             burst_left  = 0;
    bit             no_gaps     = 1'b0;

    stim_row_t      directed_tbl[$];

    // Works out how many LEDs a speed lights under the current registers.
    function automatic bar_level_t bar_level(input logic [slbu_pkg::SPEED_W-1:0] speed);
        int unsigned    ramp_lo;
        int unsigned    ramp_len;
        int unsigned    spd;
        bar_level_t     lv;
        spd      = 32'(speed);
        ramp_lo  = (reg_limit > reg_span) ? reg_limit - reg_span : 0;
        lv.over  = (spd >= reg_limit);
        lv.lit   = 0;
        if (lv.over) begin
            lv.lit = BAR_LEDS;
        end else if (spd > ramp_lo) begin
            ramp_len = reg_limit - ramp_lo;
            if (ramp_len > 0)
                lv.lit = ((spd - ramp_lo) * BAR_LEDS) / ramp_len;
            if (lv.lit > BAR_LEDS)
                lv.lit = BAR_LEDS;
        end
        return lv;
    endfunction

    function automatic logic [slbu_pkg::CODE_W-1:0] lit_colour(input int unsigned idx,
                                                               input bit over);
        if (over)
            return slbu_pkg::COL_BLUE;
        if (idx <= slbu_pkg::GREEN_LAST)
            return slbu_pkg::COL_GREEN;
        if (idx <= slbu_pkg::YELLOW_LAST)
            return slbu_pkg::COL_YELLOW;
        return slbu_pkg::COL_RED;
    endfunction

    // Turns a new bar level into the repaints it causes and moves the painted
    // state on. A full redraw is due on the first sample and whenever the
    // palette or the over-limit flag differs from the last repaint.
    function automatic void plan_repaints(input bar_level_t lv);
        bit         full;
        int         count;
        repaint_t   rp;
        count = 0;
        full  = !shown_once || (reg_dark != shown_dark) || (lv.over != shown_over);
        if (!full && lv.lit == shown_lit)
            return;
        for (int unsigned i = 0; i < BAR_LEDS; i++) begin
            rp.led  = i[slbu_pkg::INDEX_W-1:0];
            rp.dark = reg_dark;
            rp.last = 1'b0;
            if (full) begin
                rp.colour = (i < lv.lit) ? lit_colour(i, lv.over) : slbu_pkg::COL_BACKGROUND;
                repaint_q.push_back(rp);
                count++;
            end else if (lv.lit > shown_lit && i >= shown_lit && i < lv.lit) begin
                rp.colour = lit_colour(i, lv.over);
                repaint_q.push_back(rp);
                count++;
            end else if (lv.lit < shown_lit && i >= lv.lit && i < shown_lit) begin
                rp.colour = slbu_pkg::COL_BACKGROUND;
                repaint_q.push_back(rp);
                count++;
            end
        end
        if (count > 0)
            repaint_q[repaint_q.size()-1].last = 1'b1;
        shown_lit  = lv.lit;
        shown_once = 1'b1;
        shown_dark = reg_dark;
        shown_over = lv.over;
    endfunction

    function automatic stim_row_t mk_row(input row_kind_t kind,
                                         input logic [slbu_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [slbu_pkg::CFG_DAT_W-1:0] value,
                                         input bit known, input int lit, input bit over);
        stim_row_t r;
        r.kind        = kind;
        r.reg_idx     = idx;
        r.value       = value;
        r.known_level = known;
        r.lit         = lit;
        r.over        = over;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d (at %0t)", what, got, want, $realtime);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // Sender side. Samples go out in bursts of random length; a gap between
    // bursts drops s_tvalid for a random number of cycles. The expected
    // repaints are planned at the edge on which the sample transfer happens.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [slbu_pkg::SPEED_W-1:0] speed, input bit known,
                               input int lit, input bit over);
        int         gap;
        bar_level_t lv;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= speed;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (known) begin
            lv.lit  = lit;
            lv.over = over;
        end else begin
            lv = bar_level(speed);
        end
        plan_repaints(lv);
    endtask

    // Holds the sender back until every planned repaint has been seen.
    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (repaint_q.size() != 0);
    endtask

    // Register writes happen only with the block idle: everything drained and
    // enough cycles passed for a sample that causes no repaint to finish.
    task automatic write_reg(input logic [slbu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slbu_pkg::CFG_DAT_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            slbu_pkg::CFG_SPEED_LIMIT:  reg_limit = 32'(value);
            slbu_pkg::CFG_RAMP_SPAN:    reg_span  = 32'(value);
            slbu_pkg::CFG_DARK_PALETTE: reg_dark  = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side. m_tready follows one of four patterns, drawn anew when a
    // countdown runs out: always ready, ready when a phase counter is a multiple
    // of three, coin toss, and long stalls broken by short ready windows.
    // ------------------------------------------------------------------------
    int rx_mode  = 0;
    int rx_count = 0;
    int rx_phase = 0;

    always @(posedge aclk) begin
        if (rx_count == 0) begin
            rx_mode  = $urandom_range(0, 3);
            rx_count = 48;
        end
        rx_count--;
        rx_phase = (rx_phase + 1) % 16;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= (rx_phase % 3 == 0);
            2:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (rx_phase >= 12);
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: every repaint transfer is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        repaint_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (repaint_q.size() == 0) begin
                report_mismatch("repaint with none expected, led_index",
                                int'(m_tdata[3:0]), -1);
            end else begin
                want = repaint_q.pop_front();
                if (m_tdata[3:0] !== want.led)
                    report_mismatch("led_index", int'(m_tdata[3:0]), int'(want.led));
                if (m_tdata[6:4] !== want.colour)
                    report_mismatch("color_code", int'(m_tdata[6:4]), int'(want.colour));
                if (m_tdata[7] !== want.dark)
                    report_mismatch("palette_dark", int'(m_tdata[7]), int'(want.dark));
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", int'(m_tlast), int'(want.last));
            end
        end
    end

    // Cycles since the last transfer on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_CYC)
            @(posedge aclk);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYC);
        $display("[shift_light_bar_updater_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned    ramp_lo;
        int unsigned    lo;
        int unsigned    hi;
        logic [15:0]    lim;
        logic [15:0]    spn;
        logic [15:0]    spd;
        stim_row_t      r;

        // Directed table. The registers start at their reset values: limit
        // 8000 and span 1200, so the ramp runs from 6800 to 8000.
        // The first sample redraws the whole bar dark; the same level again
        // gives nothing.
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd0,
                                      1'b1, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd0,
                                      1'b1, 0, 1'b0));
        // Top of the speed range, then exactly at the limit: full and blue.
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'hFFFF,
                                      1'b1, BAR_LEDS, 1'b1));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd8000,
                                      1'b1, BAR_LEDS, 1'b1));
        // Just under the limit: leaving over-limit forces a full redraw.
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd7999,
                                      1'b0, 0, 1'b0));
        // At the ramp start the bar goes dark, just above it stays dark.
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd6800,
                                      1'b1, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd6801,
                                      1'b0, 0, 1'b0));
        // The count grows, then shrinks.
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd7400,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd7000,
                                      1'b0, 0, 1'b0));
        // A palette change redraws the bar at the same level.
        directed_tbl.push_back(mk_row(ROW_WRITE,  slbu_pkg::CFG_DARK_PALETTE, 16'd1,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd7000,
                                      1'b0, 0, 1'b0));
        // A limit of zero puts every sample over the limit.
        directed_tbl.push_back(mk_row(ROW_WRITE,  slbu_pkg::CFG_SPEED_LIMIT, 16'd0,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd0,
                                      1'b1, BAR_LEDS, 1'b1));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'hFFFF,
                                      1'b1, BAR_LEDS, 1'b1));
        // Largest limit and span: the ramp start saturates at zero.
        directed_tbl.push_back(mk_row(ROW_WRITE,  slbu_pkg::CFG_SPEED_LIMIT, 16'hFFFF,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_WRITE,  slbu_pkg::CFG_RAMP_SPAN,   16'hFFFF,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'hFFFE,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'hFFFF,
                                      1'b1, BAR_LEDS, 1'b1));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd1,
                                      1'b0, 0, 1'b0));
        // A span of zero leaves no ramp at all.
        directed_tbl.push_back(mk_row(ROW_WRITE,  slbu_pkg::CFG_RAMP_SPAN,   16'd0,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'hFFFE,
                                      1'b1, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'hFFFF,
                                      1'b1, BAR_LEDS, 1'b1));
        // A span larger than a small limit, light palette again.
        directed_tbl.push_back(mk_row(ROW_WRITE,  slbu_pkg::CFG_SPEED_LIMIT, 16'd100,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_WRITE,  slbu_pkg::CFG_RAMP_SPAN,   16'd1000,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_WRITE,  slbu_pkg::CFG_DARK_PALETTE, 16'd0,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd50,
                                      1'b0, 0, 1'b0));
        directed_tbl.push_back(mk_row(ROW_SAMPLE, slbu_pkg::CFG_SPEED_LIMIT, 16'd99,
                                      1'b0, 0, 1'b0));

        // Reset is held at the start of the run, once only.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_tbl[i]) begin
            r = directed_tbl[i];
            if (r.kind == ROW_WRITE)
                write_reg(r.reg_idx, r.value);
            else
                send_sample(r.value, r.known_level, r.lit, r.over);
        end

        // Random phases. Each phase picks its own registers, with the extremes
        // coming up now and then, and mostly sweeps samples across the ramp.
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       lim = 16'd0;
                1:       lim = 16'hFFFF;
                2:       lim = 16'($urandom);
                default: lim = 16'($urandom_range(500, 9000));
            endcase
            case ($urandom_range(0, 5))
                0:       spn = 16'd0;
                1:       spn = 16'hFFFF;
                2:       spn = 16'($urandom);
                default: spn = 16'($urandom_range(1, 2000));
            endcase
            write_reg(slbu_pkg::CFG_SPEED_LIMIT, lim);
            write_reg(slbu_pkg::CFG_RAMP_SPAN, spn);
            write_reg(slbu_pkg::CFG_DARK_PALETTE, {15'd0, 1'($urandom_range(0, 1))});
            no_gaps = ($urandom_range(0, 3) == 0);

            ramp_lo = (reg_limit > reg_span) ? reg_limit - reg_span : 0;
            lo      = (ramp_lo > 20) ? ramp_lo - 20 : 0;
            hi      = (reg_limit + 20 > 16'hFFFF) ? 16'hFFFF : reg_limit + 20;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Now and then the sender waits for the bar to catch up.
                if (n == PHASE_ITEMS / 2 && ph % 2 == 0)
                    wait_drained();
                case ($urandom_range(0, 9))
                    0:       spd = 16'($urandom);
                    1:       spd = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                    default: spd = 16'($urandom_range(lo, hi));
                endcase
                send_sample(spd, 1'b0, 0, 1'b0);
            end
        end

        // Let the last repaints arrive, then watch for strays.
        wait_drained();
        repeat (DRAIN_CYC) @(posedge aclk);

        if (fail_count == 0 && repaint_q.size() == 0)
            $display("[shift_light_bar_updater_core] OK");
        else
            $display("[shift_light_bar_updater_core] ERROR");
        $finish;
    end

endmodule

@@ shift_light_bar_updater_core.f @@
src/slbu_pkg.sv
src/slbu_seq.sv
src/slbu_datapath.sv
src/shift_light_bar_updater_core.sv
tb/sv/tb_shift_light_bar_updater_core.sv
